FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue unit.
// Used by spq_ctrl, spq_datapath and stable_priority_queue_unit; no dependencies.
package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ID_WIDTH_DEF   = 8;
    localparam int PRIO_WIDTH_DEF = 8;

    // Operation codes on the func field
    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    // Output register occupancy
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture a result this cycle
        logic insert;      // write the request into the store
        logic pop;         // remove the head entry
        logic flag_full;   // insert dropped
        logic flag_empty;  // pop on an empty store
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } status_t;

endpackage

FILE: hw/rtl/stable_priority_queue_unit.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    func, req_id, req_priority
// rsp       rsp_valid / rsp_stall  out_id, out_valid, was_empty, was_full, fill_count
//
// One operation per cycle: an insert or pop updates the sorted cell row in the
// cycle of its transfer, and the result appears from the result register next cycle.
// The result register is the only buffer, so in_stall follows rsp_stall while a
// result is held. Reset clears the occupancy and control; entries carry no reset.
// Top level of the stable priority queue. Depends on spq_pkg, spq_ctrl, spq_datapath.
module stable_priority_queue_unit #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [ID_WIDTH-1:0]          req_id,
    input  logic [PRIO_WIDTH-1:0]        req_priority,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [ID_WIDTH-1:0]          out_id,
    output logic                         out_valid,
    output logic                         was_empty,
    output logic                         was_full,
    output logic [$clog2(DEPTH+1)-1:0]   fill_count
);

    spq_pkg::cmd_t    cmd;
    spq_pkg::status_t status;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH      (DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_id       (req_id),
        .req_priority (req_priority),
        .out_id       (out_id),
        .out_valid    (out_valid),
        .was_empty    (was_empty),
        .was_full     (was_full),
        .fill_count   (fill_count)
    );

`ifndef SYNTHESIS
    localparam int CW = $clog2(DEPTH + 1);

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_valid |-> !was_empty && !was_full)
        else $error("popped entry reported together with empty or full flag");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> fill_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && was_full |-> fill_count == CW'(DEPTH))
        else $error("insert dropped while store not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && was_empty |-> fill_count == '0 && out_id == '0)
        else $error("empty pop with entries present");
`endif

endmodule

FILE: hw/rtl/spq_ctrl.sv
// Controller for the stable priority queue: input acceptance, result hold
// and command generation. Depends on spq_pkg.
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  spq_pkg::status_t   status,
    output spq_pkg::cmd_t      cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            accept;
    logic            is_pop;

    assign is_pop = (func == spq_pkg::FUNC_POP);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = spq_pkg::ST_HOLD;
                end
            end
            spq_pkg::ST_HOLD:
            begin
                if (!rsp_stall && !accept)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall  = 1'b0;
        rsp_valid = 1'b0;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                rsp_valid = 1'b0;
            end
            spq_pkg::ST_HOLD:
            begin
                // take a new transfer only while the held result leaves
                in_stall  = rsp_stall;
                rsp_valid = 1'b1;
            end
            default:
            begin
                in_stall  = 1'b1;
                rsp_valid = 1'b0;
            end
        endcase
        accept         = in_valid && !in_stall;
        cmd.load       = accept;
        cmd.insert     = accept && !is_pop && !status.full;
        cmd.pop        = accept && is_pop && !status.empty;
        cmd.flag_full  = accept && !is_pop && status.full;
        cmd.flag_empty = accept && is_pop && status.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/spq_datapath.sv
// Datapath for the stable priority queue: sorted row of entry cells with a
// per-cell compare-and-shift, occupancy counter and result register. Depends on spq_pkg.
module spq_datapath #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spq_pkg::cmd_t         cmd,
    output spq_pkg::status_t      status,
    input  logic [ID_WIDTH-1:0]   req_id,
    input  logic [PRIO_WIDTH-1:0] req_priority,
    output logic [ID_WIDTH-1:0]   out_id,
    output logic                  out_valid,
    output logic                  was_empty,
    output logic                  was_full,
    output logic [CW-1:0]         fill_count
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [ID_WIDTH-1:0]   id_reg   [DEPTH];
    logic [PRIO_WIDTH-1:0] prio_reg [DEPTH];
    logic [DEPTH-1:0]      gt;
    logic [CW-1:0]         occ_reg;
    logic [CW-1:0]         occ_next;

    logic [ID_WIDTH-1:0]   out_id_reg;
    logic                  out_valid_reg;
    logic                  was_empty_reg;
    logic                  was_full_reg;
    logic [CW-1:0]         fill_count_reg;

    assign status.full  = (occ_reg == FULL_COUNT);
    assign status.empty = (occ_reg == '0);

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.insert)
        begin
            occ_next = occ_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            occ_next = occ_reg - CW'(1);
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(i);
            logic prev_gt;
            logic at_end;

            // live entry that must move behind the new request
            assign gt[i]  = (IDX < occ_reg) && (prio_reg[i] > req_priority);
            assign at_end = (IDX == occ_reg);

            if (i == 0)
            begin : g_first
                assign prev_gt = 1'b0;
            end
            else
            begin : g_rest
                assign prev_gt = gt[i-1];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.insert)
                begin
                    if (prev_gt)
                    begin
                        if (i > 0)
                        begin
                            id_reg[i]   <= id_reg[(i > 0) ? i - 1 : 0];
                            prio_reg[i] <= prio_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    else if (gt[i] || at_end)
                    begin
                        id_reg[i]   <= req_id;
                        prio_reg[i] <= req_priority;
                    end
                end
                else if (cmd.pop)
                begin
                    // advance toward the head
                    if (i < DEPTH - 1)
                    begin
                        id_reg[i]   <= id_reg[(i < DEPTH - 1) ? i + 1 : i];
                        prio_reg[i] <= prio_reg[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_id_reg     <= cmd.pop ? id_reg[0] : '0;
            out_valid_reg  <= cmd.pop;
            was_empty_reg  <= cmd.flag_empty;
            was_full_reg   <= cmd.flag_full;
            fill_count_reg <= occ_next;
        end
    end

    assign out_id     = out_id_reg;
    assign out_valid  = out_valid_reg;
    assign was_empty  = was_empty_reg;
    assign was_full   = was_full_reg;
    assign fill_count = fill_count_reg;

endmodule
